/* hw/rtl/near_far_word_lz_decoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the near/far word LZ decoder
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NEAR_FAR_WORD_LZ_DECODER_UNIT_MACROS_SVH
`define NEAR_FAR_WORD_LZ_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define NFWLZ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfwlz: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define NFWLZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfwlz: next-cycle check failed");

`else

`define NFWLZ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define NFWLZ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/nfwlz_pkg.sv */
// ----------------------------------------------------------------------------
// nfwlz_pkg
// Types and constants shared by the decoder and its channel interfaces.
// ----------------------------------------------------------------------------
package nfwlz_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int LEN_W   = 16;
    localparam int LEFT_W  = LEN_W - 1;
    localparam int COUNT_W = 3;
    localparam int PACK_N  = 4;

    localparam logic [BYTE_W-1:0] NEAR_TAG = 8'hA7;
    localparam logic [BYTE_W-1:0] FAR_TAG  = 8'hA8;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERRUN  = 2'd1,
        STAT_BAD_REF  = 2'd2,
        STAT_TOO_LONG = 2'd3
    } status_t;

endpackage

/* hw/rtl/nfwlz_ifs.sv */
// ----------------------------------------------------------------------------
// nfwlz channel interfaces
// Valid/ready channels for compressed input bytes and packed output words.
// ----------------------------------------------------------------------------
interface nfwlz_in_if import nfwlz_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               start_req;
    logic [LEN_W-1:0]   expanded_bytes;
    byte_t              data_byte;

    modport source (output valid, output start_req, output expanded_bytes,
                    output data_byte, input ready);
    modport sink   (input valid, input start_req, input expanded_bytes,
                    input data_byte, output ready);
endinterface

interface nfwlz_out_if import nfwlz_pkg::*; ();
    logic               valid;
    logic               ready;
    word_t              word_a;
    word_t              word_b;
    word_t              word_c;
    word_t              word_d;
    logic [COUNT_W-1:0] word_count;
    logic               last;
    status_t            status;

    modport source (output valid, output word_a, output word_b, output word_c,
                    output word_d, output word_count, output last, output status,
                    input ready);
    modport sink   (input valid, input word_a, input word_b, input word_c,
                    input word_d, input word_count, input last, input status,
                    output ready);
endinterface

/* hw/rtl/near_far_word_lz_decoder_unit.sv */
// ----------------------------------------------------------------------------
// near_far_word_lz_decoder_unit
// Expands a near/far word LZ stream, one compressed byte per transaction,
// into 16-bit words packed up to four to an output transaction.
// ----------------------------------------------------------------------------
// A stream opens with a start transaction carrying the expanded length in
// bytes; every later input transaction carries one compressed byte. Bytes
// that complete no word and close no stream are accepted and need nothing more. A
// start or byte that closes a stream without producing words (an empty or
// oversized length, a length overrun or a bad reference) is accepted and
// then loads the output register. A byte that completes a literal is
// accepted, writes one word into the history memory and then loads the
// output register. A byte that completes a copy of n words is accepted;
// then each copied word takes one registered read and then one write of
// the history memory, and every fourth word, and the last of the copy,
// hands the packed group to the output register. Waits on the output
// channel hold the sequencer in its output state. The input is not ready
// while a byte is being expanded. The history memory needs no clearing pass
// after reset, and a stream never reads a word it has not written itself.
// ----------------------------------------------------------------------------
`include "near_far_word_lz_decoder_unit_macros.svh"

module near_far_word_lz_decoder_unit
    import nfwlz_pkg::*;
#(
    parameter int HISTORY_WORDS = 8192
)
(
    input  logic         clk,
    input  logic         rst_n,
    nfwlz_in_if.sink     in_ch,
    nfwlz_out_if.source  out_ch
);

    // Address width of the history memory, and the write index width, which
    // must also hold the full capacity.
    localparam int AW   = $clog2(HISTORY_WORDS);
    localparam int WI_W = $clog2(HISTORY_WORDS + 1);

    // Sequencer states: waiting for a transaction, reading a history word,
    // writing a produced word, and handing a packed group to the output.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_EMIT
    } state_t;

    // Position in the compressed token grammar.
    typedef enum logic [2:0] {
        P_IDLE,
        P_WORD_LO,
        P_WORD_HI,
        P_TAG_FILL,
        P_NEAR_OFF,
        P_FAR_LO,
        P_FAR_HI
    } phase_t;

    state_t              state_reg,     state_next;
    phase_t              phase_reg,     phase_next;
    logic [WI_W-1:0]     wi_reg,        wi_next;
    logic [LEFT_W-1:0]   wl_reg,        wl_next;
    word_t               held_reg,      held_next;
    byte_t               hol_reg,       hol_next;
    logic [WI_W-1:0]     src_reg,       src_next;
    byte_t               rem_reg,       rem_next;
    word_t               lit_word_reg,  lit_word_next;
    logic                lit_mode_reg,  lit_mode_next;
    word_t               pk_word_reg [PACK_N];
    word_t               pk_word_next [PACK_N];
    logic [COUNT_W-1:0]  pk_cnt_reg,    pk_cnt_next;
    logic                fin_last_reg,  fin_last_next;
    status_t             fin_stat_reg,  fin_stat_next;
    logic                ov_reg,        ov_next;
    word_t               oa_reg,        oa_next;
    word_t               ob_reg,        ob_next;
    word_t               oc_reg,        oc_next;
    word_t               od_reg,        od_next;
    logic [COUNT_W-1:0]  ocnt_reg,      ocnt_next;
    logic                olast_reg,     olast_next;
    status_t             ostat_reg,     ostat_next;

    // History memory with a registered read port.
    word_t               hist_mem [HISTORY_WORDS];
    word_t               mem_q;
    word_t               wr_word;
    logic                in_fire;
    logic [LEN_W-1:0]    far_off;
    byte_t               b;
    logic                err_out;
    logic                empty_start;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign b       = in_ch.data_byte;
    assign far_off = {b, hol_reg};
    assign wr_word = lit_mode_reg ? lit_word_reg : mem_q;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            mem_q <= hist_mem[src_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR)
        begin
            hist_mem[wi_reg[AW-1:0]] <= wr_word;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        wi_next       = wi_reg;
        wl_next       = wl_reg;
        held_next     = held_reg;
        hol_next      = hol_reg;
        src_next      = src_reg;
        rem_next      = rem_reg;
        lit_word_next = lit_word_reg;
        lit_mode_next = lit_mode_reg;
        pk_word_next  = pk_word_reg;
        pk_cnt_next   = pk_cnt_reg;
        fin_last_next = fin_last_reg;
        fin_stat_next = fin_stat_reg;
        ov_next       = ov_reg;
        oa_next       = oa_reg;
        ob_next       = ob_reg;
        oc_next       = oc_reg;
        od_next       = od_reg;
        ocnt_next     = ocnt_reg;
        olast_next    = olast_reg;
        ostat_next    = ostat_reg;

        if (out_ch.valid && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_ch.start_req)
                begin
                    // A start abandons whatever stream was in progress.
                    wl_next   = in_ch.expanded_bytes[LEN_W-1:1];
                    wi_next   = '0;
                    held_next = '0;
                    hol_next  = '0;
                    if (32'(in_ch.expanded_bytes[LEN_W-1:1]) > 32'(HISTORY_WORDS))
                    begin
                        phase_next    = P_IDLE;
                        wl_next       = '0;
                        fin_last_next = 1'b1;
                        fin_stat_next = STAT_TOO_LONG;
                        pk_cnt_next   = '0;
                        rem_next      = '0;
                        state_next    = S_EMIT;
                    end
                    else if (in_ch.expanded_bytes[LEN_W-1:1] == '0)
                    begin
                        phase_next    = P_IDLE;
                        fin_last_next = 1'b1;
                        fin_stat_next = STAT_OK;
                        pk_cnt_next   = '0;
                        rem_next      = '0;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        phase_next = P_WORD_LO;
                    end
                end
                else if (in_fire)
                begin
                    unique case (phase_reg)
                        P_WORD_LO:
                        begin
                            held_next  = {8'h00, b};
                            phase_next = P_WORD_HI;
                        end
                        P_WORD_HI:
                        begin
                            held_next = {b, held_reg[7:0]};
                            if (b == NEAR_TAG || b == FAR_TAG)
                            begin
                                if (held_reg[7:0] == 8'h00)
                                begin
                                    phase_next = P_TAG_FILL;
                                end
                                else if (b == NEAR_TAG)
                                begin
                                    phase_next = P_NEAR_OFF;
                                end
                                else
                                begin
                                    phase_next = P_FAR_LO;
                                end
                            end
                            else
                            begin
                                lit_word_next = {b, held_reg[7:0]};
                                lit_mode_next = 1'b1;
                                rem_next      = 8'd1;
                                state_next    = S_WR;
                            end
                        end
                        P_TAG_FILL:
                        begin
                            lit_word_next = {held_reg[15:8], b};
                            lit_mode_next = 1'b1;
                            rem_next      = 8'd1;
                            state_next    = S_WR;
                        end
                        P_NEAR_OFF:
                        begin
                            if (32'(held_reg[7:0]) > 32'(wl_reg))
                            begin
                                phase_next    = P_IDLE;
                                wl_next       = '0;
                                fin_last_next = 1'b1;
                                fin_stat_next = STAT_OVERRUN;
                                rem_next      = '0;
                                state_next    = S_EMIT;
                            end
                            else if (b == 8'h00 || 32'(b) > 32'(wi_reg))
                            begin
                                phase_next    = P_IDLE;
                                wl_next       = '0;
                                fin_last_next = 1'b1;
                                fin_stat_next = STAT_BAD_REF;
                                rem_next      = '0;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                src_next      = wi_reg - WI_W'(b);
                                rem_next      = held_reg[7:0];
                                lit_mode_next = 1'b0;
                                state_next    = S_RD;
                            end
                        end
                        P_FAR_LO:
                        begin
                            hol_next   = b;
                            phase_next = P_FAR_HI;
                        end
                        P_FAR_HI:
                        begin
                            if (32'(held_reg[7:0]) > 32'(wl_reg))
                            begin
                                phase_next    = P_IDLE;
                                wl_next       = '0;
                                fin_last_next = 1'b1;
                                fin_stat_next = STAT_OVERRUN;
                                rem_next      = '0;
                                state_next    = S_EMIT;
                            end
                            else if (32'(far_off) >= 32'(wi_reg))
                            begin
                                phase_next    = P_IDLE;
                                wl_next       = '0;
                                fin_last_next = 1'b1;
                                fin_stat_next = STAT_BAD_REF;
                                rem_next      = '0;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                // Offset is below the write index, so it fits.
                                src_next      = WI_W'(far_off);
                                rem_next      = held_reg[7:0];
                                lit_mode_next = 1'b0;
                                state_next    = S_RD;
                            end
                        end
                        default:
                        begin
                            // Bytes outside a stream are dropped.
                            phase_next = P_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                pk_word_next[pk_cnt_reg[1:0]] = wr_word;
                pk_cnt_next = pk_cnt_reg + 3'd1;
                wi_next     = wi_reg + 1'b1;
                wl_next     = wl_reg - 1'b1;
                rem_next    = rem_reg - 8'd1;
                src_next    = src_reg + 1'b1;
                if (rem_reg == 8'd1)
                begin
                    fin_last_next = (wl_reg == LEFT_W'(1));
                    fin_stat_next = STAT_OK;
                    phase_next    = (wl_reg == LEFT_W'(1)) ? P_IDLE : P_WORD_LO;
                    state_next    = S_EMIT;
                end
                else if (pk_cnt_reg == 3'd3)
                begin
                    fin_last_next = 1'b0;
                    fin_stat_next = STAT_OK;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next     = 1'b1;
                    oa_next     = (pk_cnt_reg > 3'd0) ? pk_word_reg[0] : '0;
                    ob_next     = (pk_cnt_reg > 3'd1) ? pk_word_reg[1] : '0;
                    oc_next     = (pk_cnt_reg > 3'd2) ? pk_word_reg[2] : '0;
                    od_next     = (pk_cnt_reg > 3'd3) ? pk_word_reg[3] : '0;
                    ocnt_next   = pk_cnt_reg;
                    olast_next  = fin_last_reg;
                    ostat_next  = fin_stat_reg;
                    pk_cnt_next = '0;
                    state_next  = (rem_reg != 8'd0) ? S_RD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= P_IDLE;
            wi_reg       <= '0;
            wl_reg       <= '0;
            held_reg     <= '0;
            hol_reg      <= '0;
            src_reg      <= '0;
            rem_reg      <= '0;
            lit_word_reg <= '0;
            lit_mode_reg <= 1'b0;
            for (int i = 0; i < PACK_N; i++)
            begin
                pk_word_reg[i] <= '0;
            end
            pk_cnt_reg   <= '0;
            fin_last_reg <= 1'b0;
            fin_stat_reg <= STAT_OK;
            ov_reg       <= 1'b0;
            oa_reg       <= '0;
            ob_reg       <= '0;
            oc_reg       <= '0;
            od_reg       <= '0;
            ocnt_reg     <= '0;
            olast_reg    <= 1'b0;
            ostat_reg    <= STAT_OK;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            wi_reg       <= wi_next;
            wl_reg       <= wl_next;
            held_reg     <= held_next;
            hol_reg      <= hol_next;
            src_reg      <= src_next;
            rem_reg      <= rem_next;
            lit_word_reg <= lit_word_next;
            lit_mode_reg <= lit_mode_next;
            pk_word_reg  <= pk_word_next;
            pk_cnt_reg   <= pk_cnt_next;
            fin_last_reg <= fin_last_next;
            fin_stat_reg <= fin_stat_next;
            ov_reg       <= ov_next;
            oa_reg       <= oa_next;
            ob_reg       <= ob_next;
            oc_reg       <= oc_next;
            od_reg       <= od_next;
            ocnt_reg     <= ocnt_next;
            olast_reg    <= olast_next;
            ostat_reg    <= ostat_next;
        end
    end

    // The input is taken only between bytes, when the sequencer is free.
    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = ov_reg;
    assign out_ch.word_a     = oa_reg;
    assign out_ch.word_b     = ob_reg;
    assign out_ch.word_c     = oc_reg;
    assign out_ch.word_d     = od_reg;
    assign out_ch.word_count = ocnt_reg;
    assign out_ch.last       = olast_reg;
    assign out_ch.status     = ostat_reg;

    // Conditions watched by the checks below.
    assign err_out     = out_ch.valid && (out_ch.status != STAT_OK);
    assign empty_start = in_fire && in_ch.start_req && (in_ch.expanded_bytes[LEN_W-1:1] == '0);

    // An error status only ever closes a stream, and carries no words.
    `NFWLZ_ASSERT_IMPLY(a_err_is_final, clk, rst_n, err_out, out_ch.last && out_ch.word_count == '0)

    // Between bytes the packing buffer is empty and no copy is pending.
    `NFWLZ_ASSERT_IMPLY(a_idle_clean, clk, rst_n, in_ch.ready, pk_cnt_reg == '0 && rem_reg == '0)

    // The write index never passes the history capacity.
    `NFWLZ_ASSERT_IMPLY(a_wi_in_range, clk, rst_n, 1'b1, 32'(wi_reg) <= 32'(HISTORY_WORDS))

    // A start for an empty stream goes straight to the output stage.
    `NFWLZ_ASSERT_NEXT(a_empty_start, clk, rst_n, empty_start, state_reg == S_EMIT)

endmodule
